FILE: src/ts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_pkg
// Shared types and constants for the timestamp-to-milliseconds parser.
// ----------------------------------------------------------------------------
package ts_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned MS_W     = 64;
  localparam int unsigned NUM_FIELDS = 4;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned FIELD_W  = 2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  localparam logic [FIELD_W-1:0] FIELD_MS     = 2'd3;
  localparam logic [1:0]         MS_DIGIT_MAX = 2'd3;
  localparam logic [POS_W-1:0]   MIN_SEPS     = 3'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_MIN,
    ST_MIX_SEC,
    ST_MIX_MS,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_MIN,
    STEP_SEC,
    STEP_MS
  } calc_step_t;

  typedef struct packed {
    logic       take_char;
    calc_step_t step;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage : ts_pkg
`default_nettype wire

FILE: src/ts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_in_if / ts_out_if
// Valid/ready channels for line characters in and parsed results out.
// ----------------------------------------------------------------------------
interface ts_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface : ts_in_if

interface ts_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] milliseconds;

  modport source (output valid, output ok, output milliseconds, input ready);
  modport sink   (input valid, input ok, input milliseconds, output ready);
endinterface : ts_out_if
`default_nettype wire

FILE: src/ts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_datapath
// Field registers, per-line parse state, total accumulator and result register.
// ----------------------------------------------------------------------------
module ts_datapath
  import ts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  input  wire logic [CHAR_W-1:0] char_code,
  output dp_status_t             status,
  ts_out_if.source               result_out
);

  logic [MS_W-1:0]  field_values [NUM_FIELDS];
  logic [POS_W-1:0] field_position;
  logic [1:0]       digit_count;
  logic             seen_digit;
  logic             line_failed;
  logic [MS_W-1:0]  acc;
  logic             out_valid;
  logic             out_ok;
  logic [MS_W-1:0]  out_ms;

  logic [FIELD_W-1:0] fidx;
  logic [MS_W-1:0]    cur_field;
  logic [MS_W-1:0]    digit_value;
  logic               is_digit;
  logic               is_sep;
  logic               is_blank;
  logic               active;
  logic               line_ok;
  logic [MS_W-1:0]    acc_next;

  assign fidx        = field_position[FIELD_W-1:0];
  assign cur_field   = field_values[fidx];
  assign digit_value = (cur_field << 3) + (cur_field << 1)
                     + {{(MS_W-4){1'b0}}, char_code[3:0]};
  assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sep      = (char_code == CH_COLON) || (char_code == CH_COMMA)
                     || (char_code == CH_DOT);
  assign is_blank    = (char_code == CH_SPACE) || (char_code == CH_TAB);
  assign active      = !line_failed && !field_position[POS_W-1];
  assign line_ok     = !line_failed && (field_position >= MIN_SEPS);

  always_comb begin
    unique case (cmd.step)
      STEP_MIN: acc_next = field_values[1] + (field_values[0] << 6) - (field_values[0] << 2);
      STEP_SEC: acc_next = field_values[2] + (acc << 6) - (acc << 2);
      STEP_MS:  acc_next = field_values[3] + (acc << 10) - (acc << 5) + (acc << 3);
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (cmd.finish) begin
      out_ok <= line_ok;
      out_ms <= line_ok ? acc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_values[i] <= '0;
      end
      field_position <= '0;
      digit_count    <= '0;
      seen_digit     <= 1'b0;
      line_failed    <= 1'b0;
    end else if (cmd.take_char && active) begin
      if (is_digit) begin
        if (!(fidx == FIELD_MS && digit_count >= MS_DIGIT_MAX)) begin
          field_values[fidx] <= digit_value;
          if (digit_count < MS_DIGIT_MAX) begin
            digit_count <= digit_count + 2'd1;
          end
          seen_digit <= 1'b1;
        end
      end else if (is_sep) begin
        if (!seen_digit) begin
          line_failed <= 1'b1;
        end else begin
          field_position <= field_position + 3'd1;
          digit_count    <= '0;
        end
      end else if (!is_blank) begin
        line_failed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_busy         = out_valid && !result_out.ready;
  assign result_out.valid        = out_valid;
  assign result_out.ok           = out_ok;
  assign result_out.milliseconds = out_ms;

endmodule : ts_datapath
`default_nettype wire

FILE: src/ts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_ctrl
// Sequencer: takes characters, runs the end-of-line total and hands off.
// ----------------------------------------------------------------------------
module ts_ctrl
  import ts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_kind,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.take_char = 1'b0;
    cmd.step      = STEP_NONE;
    cmd.finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_EOL) begin
            state_next = ST_MIX_MIN;
          end else begin
            cmd.take_char = 1'b1;
          end
        end
      end
      ST_MIX_MIN: begin
        cmd.step   = STEP_MIN;
        state_next = ST_MIX_SEC;
      end
      ST_MIX_SEC: begin
        cmd.step   = STEP_SEC;
        state_next = ST_MIX_MS;
      end
      ST_MIX_MS: begin
        cmd.step   = STEP_MS;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule : ts_ctrl
`default_nettype wire

FILE: src/lenient_timestamp_to_ms_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lenient_timestamp_to_ms_parser
// Parses one timestamp line, character by character, into milliseconds.
// ----------------------------------------------------------------------------
// A character transaction is taken while the sequencer is idle, and the next
// one may follow in the next cycle. An end-of-line transaction yields one
// result after three shift-add steps of the total (x60, x60, x1000) through
// one 64-bit accumulator, then a load of the result register, which also
// clears the line state. Input ready stays low through the steps and the load,
// and while a previous result has not been taken when the new one is due to load.
module lenient_timestamp_to_ms_parser
  import ts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ts_in_if.sink     char_in,
  ts_out_if.source  result_out
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_kind  (char_in.kind),
    .in_ready (char_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ts_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .char_code  (char_in.char_code),
    .status     (status),
    .result_out (result_out)
  );

endmodule : lenient_timestamp_to_ms_parser
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamp lines, one character per transaction and then an
// end-of-line transaction, into the parser. A scoreboard keeps its own
// line state, works out each total, and checks it against the result
// channel. Directed lines come first, then random lines: mostly well-formed,
// some broken and some noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ts_pkg::*;

  typedef struct {
    bit        ok;
    bit [63:0] ms;
  } line_total_t;

  class line_total_checker;
    bit [63:0]   field_val [NUM_FIELDS];
    bit [2:0]    field_pos;
    bit [1:0]    digit_cnt;
    bit          seen_digit;
    bit          line_bad;
    line_total_t pending_totals[$];
    int          errors;

    function void clear_line();
      foreach (field_val[i]) field_val[i] = '0;
      field_pos  = '0;
      digit_cnt  = '0;
      seen_digit = 1'b0;
      line_bad   = 1'b0;
    endfunction

    function new();
      errors = 0;
      clear_line();
    endfunction

    function int pending();
      return pending_totals.size();
    endfunction

    function void take_item(bit kind, bit [7:0] c);
      line_total_t res;
      bit [63:0]   t;
      if (kind == KIND_EOL) begin
        if (line_bad || field_pos < MIN_SEPS) begin
          res.ok = 1'b0;
          res.ms = '0;
        end else begin
          t = field_val[0];
          t = field_val[1] + 64'd60 * t;
          t = field_val[2] + 64'd60 * t;
          t = field_val[3] + 64'd1000 * t;
          res.ok = 1'b1;
          res.ms = t;
        end
        pending_totals.insert(pending_totals.size(), res);
        clear_line();
        return;
      end
      if (line_bad || field_pos >= NUM_FIELDS) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (field_pos == FIELD_MS && digit_cnt >= MS_DIGIT_MAX) return;
        field_val[field_pos] = field_val[field_pos] * 64'd10 + 64'(c - CH_ZERO);
        if (digit_cnt < MS_DIGIT_MAX) digit_cnt++;
        seen_digit = 1'b1;
      end else if (c == CH_COLON || c == CH_COMMA || c == CH_DOT) begin
        if (!seen_digit) begin
          line_bad = 1'b1;
        end else begin
          field_pos++;
          digit_cnt = '0;
        end
      end else if (c == CH_SPACE || c == CH_TAB) begin
        return;
      end else begin
        line_bad = 1'b1;
      end
    endfunction

    function void check_total(logic ok, logic [63:0] ms);
      line_total_t exp_total;
      if (pending_totals.size() == 0) begin
        $error("result with no line pending: ok=%0b milliseconds=%0d", ok, ms);
        errors++;
        return;
      end
      exp_total = pending_totals.pop_front();
      if (ok !== exp_total.ok) begin
        $error("ok: expected %0b, actual %0b", exp_total.ok, ok);
        errors++;
      end
      if (ms !== exp_total.ms) begin
        $error("milliseconds: expected %0d, actual %0d", exp_total.ms, ms);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ts_in_if  char_in ();
  ts_out_if result_out ();

  lenient_timestamp_to_ms_parser dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .result_out(result_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  line_total_checker board = new();
  int                items_sent = 0;
  int                results_seen = 0;
  bit                steady_tx = 1'b0;
  bit [7:0]          line_buf[$];
  bit [7:0]          sep_chars[3] = '{CH_COLON, CH_COMMA, CH_DOT};

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic void append_char(bit [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  task automatic send_item(bit kind, bit [7:0] c);
    int gap;
    gap = steady_tx ? 0 : idle_gap();
    if (gap > 0) begin
      char_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_in.valid     <= 1'b1;
    char_in.kind      <= kind;
    char_in.char_code <= c;
    do @(posedge clk); while (!char_in.ready);
    board.take_item(kind, c);
    items_sent++;
  endtask

  task automatic send_text(string s, bit [7:0] eol_char);
    for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
    send_item(KIND_EOL, eol_char);
  endtask

  task automatic send_buffered_line();
    foreach (line_buf[i]) send_item(KIND_CHAR, line_buf[i]);
    send_item(KIND_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic maybe_blank();
    if ($urandom_range(0, 9) == 0)
      append_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic build_wellformed();
    int r;
    int nseps;
    int ndig;
    r = $urandom_range(0, 9);
    nseps = (r == 0) ? 1 : (r < 4) ? 2 : (r < 7) ? 3 : 4;
    for (int i = 0; i <= nseps && i < NUM_FIELDS; i++) begin
      if (i > 0 && $urandom_range(0, 14) == 0)
        ndig = 0;
      else if ($urandom_range(0, 19) == 0)
        ndig = $urandom_range(15, 25);
      else
        ndig = $urandom_range(1, (i == 3) ? 5 : 3);
      for (int j = 0; j < ndig; j++) begin
        maybe_blank();
        append_char(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if (i < nseps) begin
        maybe_blank();
        append_char(sep_chars[$urandom_range(0, 2)]);
      end
    end
    if (nseps == 4 && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) append_char(8'($urandom_range(0, 255)));
  endtask

  task automatic build_random_line();
    int r;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      build_wellformed();
    end else if (r < 85) begin
      build_wellformed();
      if ($urandom_range(0, 1) == 0)
        line_buf.push_front(sep_chars[$urandom_range(0, 2)]);
      else
        line_buf.insert($urandom_range(0, line_buf.size() - 1), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 3))
          0, 1: append_char(8'($urandom_range(0, 255)));
          2: append_char(CH_ZERO + 8'($urandom_range(0, 9)));
          default: append_char(sep_chars[$urandom_range(0, 2)]);
        endcase
      end
    end
  endtask

  // result side
  initial begin
    int  hold_cnt;
    int  run_cnt;
    bit  long_hold_done;
    bit  rdy_next;
    hold_cnt       = 0;
    run_cnt        = 0;
    long_hold_done = 1'b0;
    result_out.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result_out.valid && result_out.ready) begin
        board.check_total(result_out.ok, result_out.milliseconds);
        results_seen++;
      end
      if (results_seen == 30 && !long_hold_done) begin
        hold_cnt       = 400;
        long_hold_done = 1'b1;
      end
      if (hold_cnt == 0 && run_cnt == 0) begin
        run_cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
        hold_cnt = idle_gap();
      end
      if (hold_cnt > 0) begin
        rdy_next = 1'b0;
        hold_cnt--;
      end else begin
        rdy_next = 1'b1;
        run_cnt--;
      end
      result_out.ready <= rdy_next;
    end
  end

  // line side
  initial begin
    int line_cnt;
    line_cnt = 0;
    char_in.valid     <= 1'b0;
    char_in.kind      <= KIND_CHAR;
    char_in.char_code <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_EOL, 8'hFF);
    send_text(":", 8'h00);
    send_text("7", 8'h41);
    send_item(KIND_CHAR, "9");
    send_item(KIND_CHAR, 8'hFF);
    send_text(":1:", 8'h00);
    send_text("1:\t,2.3456:x", 8'h00);

    while (items_sent < 1350) begin
      steady_tx = ($urandom_range(0, 5) == 0);
      build_random_line();
      send_buffered_line();
      line_cnt++;
      if (line_cnt % 40 == 20) begin
        char_in.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
    end
    char_in.valid <= 1'b0;

    do @(posedge clk); while (board.pending() != 0);
    repeat (16) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule : testbench
